// ===== hdl/ohq_pkg.sv =====
// Shared types and constants for the ordered handle queue.
`timescale 1ns / 1ps
`default_nettype none
package ohq_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned ITEM_W          = 16;
  localparam int unsigned COUNT_W         = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_HAS     = 3'd2,
    CMD_HEAD    = 3'd3,
    CMD_NEXT    = 3'd4,
    CMD_CURRENT = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_FETCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              status;
    logic              found;
    logic              item_valid;
    logic [ITEM_W-1:0] item;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/ohq_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ohq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/ohq_out.sv =====
// Result holding register between the sequencer and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module ohq_out (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire ohq_pkg::res_t                res_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              status_o,
  output logic                              found_o,
  output logic                              item_valid_o,
  output logic [ohq_pkg::ITEM_W-1:0]        item_out_o,
  output logic [ohq_pkg::COUNT_W-1:0]       count_o
);

  logic          valid_q, valid_d;
  ohq_pkg::res_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign status_o     = res_q.status;
  assign found_o      = res_q.found;
  assign item_valid_o = res_q.item_valid;
  assign item_out_o   = res_q.item;
  assign count_o      = res_q.count;

endmodule
`default_nettype wire

// ===== hdl/ordered_handle_queue_core.sv =====
// Ordered handle queue: top level with command sequencer and entry store.
//
// Keeps up to DEPTH handles in insertion order in a RAM, with one cursor.
// One request is taken at a time; in_stall_o stays high while it runs. Has and
// remove walk the RAM through its single read port, one entry per cycle, and
// remove then shifts each entry after the match down by one to close the gap.
// A finished result sits in an output register, so a new request is taken
// while the previous result waits on out_stall_i.
`timescale 1ns / 1ps
`default_nettype none
module ordered_handle_queue_core #(
  parameter int unsigned DEPTH       = ohq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_BITS = ohq_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ohq_pkg::CMD_W-1:0]    command_i,
  input  wire logic [ohq_pkg::ITEM_W-1:0]   item_handle_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              status_o,
  output logic                              found_o,
  output logic                              item_valid_o,
  output logic [ohq_pkg::ITEM_W-1:0]        item_out_o,
  output logic [ohq_pkg::COUNT_W-1:0]       count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ohq_pkg::state_e state_q, state_d;

  logic [ohq_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [HANDLE_BITS-1:0]    h_q, h_d, h_in;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [IDX_W-1:0]          cur_q, cur_d;
  logic                      cur_valid_q, cur_valid_d;
  logic [CNT_W-1:0]          scan_q, scan_d;
  logic                      pend_q, pend_d;
  logic [IDX_W-1:0]          pidx_q, pidx_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic [CNT_W-1:0]          src_q, src_d;
  logic                      wpend_q, wpend_d;
  logic [IDX_W-1:0]          widx_q, widx_d;
  logic                      status_q, status_d;
  logic                      found_q, found_d;
  logic                      ivalid_q, ivalid_d;
  logic [HANDLE_BITS-1:0]    item_q, item_d;

  logic                   we;
  logic [IDX_W-1:0]       waddr, raddr;
  logic [HANDLE_BITS-1:0] wdata, rdata;

  logic             accept, hit, scan_more, src_more, out_free, load;
  logic [CNT_W-1:0] cur_ext, cur_inc, pos_ext, count_dec;
  logic [63:0]      h_wide, item_wide;
  logic [31:0]      cnt_wide;
  ohq_pkg::res_t    res;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ohq_pkg::S_IDLE);

  assign h_wide    = 64'(item_handle_i);
  assign h_in      = h_wide[HANDLE_BITS-1:0];
  assign hit       = pend_q && (rdata == h_q);
  assign scan_more = scan_q < count_q;
  assign src_more  = src_q < count_q;
  assign cur_ext   = CNT_W'(cur_q);
  assign cur_inc   = cur_ext + CNT_W'(1);
  assign pos_ext   = CNT_W'(pos_q);
  assign count_dec = count_q - CNT_W'(1);

  ohq_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ohq_pkg::S_IDLE: begin
        if (accept) state_d = ohq_pkg::S_EXEC;
      end
      ohq_pkg::S_EXEC: begin
        unique case (cmd_q)
          ohq_pkg::CMD_REMOVE, ohq_pkg::CMD_HAS: state_d = ohq_pkg::S_SCAN;
          ohq_pkg::CMD_HEAD: begin
            state_d = (count_q != '0) ? ohq_pkg::S_FETCH : ohq_pkg::S_DONE;
          end
          ohq_pkg::CMD_NEXT: begin
            state_d = (cur_valid_q && (cur_inc < count_q)) ?
                      ohq_pkg::S_FETCH : ohq_pkg::S_DONE;
          end
          ohq_pkg::CMD_CURRENT: begin
            state_d = (cur_valid_q && (cur_ext < count_q)) ?
                      ohq_pkg::S_FETCH : ohq_pkg::S_DONE;
          end
          default: state_d = ohq_pkg::S_DONE;
        endcase
      end
      ohq_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (cmd_q == ohq_pkg::CMD_REMOVE) ? ohq_pkg::S_SHIFT : ohq_pkg::S_DONE;
        end else if (!scan_more) begin
          state_d = ohq_pkg::S_DONE;
        end
      end
      ohq_pkg::S_SHIFT: begin
        if (!src_more && !wpend_q) state_d = ohq_pkg::S_DONE;
      end
      ohq_pkg::S_FETCH: state_d = ohq_pkg::S_DONE;
      ohq_pkg::S_DONE: begin
        if (out_free) state_d = ohq_pkg::S_IDLE;
      end
      default: state_d = ohq_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    cmd_d       = cmd_q;
    h_d         = h_q;
    count_d     = count_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    pos_d       = pos_q;
    src_d       = src_q;
    wpend_d     = wpend_q;
    widx_d      = widx_q;
    status_d    = status_q;
    found_d     = found_q;
    ivalid_d    = ivalid_q;
    item_d      = item_q;
    we          = 1'b0;
    waddr       = widx_q;
    wdata       = rdata;
    raddr       = '0;
    load        = 1'b0;
    unique case (state_q)
      ohq_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d = command_i;
          h_d   = h_in;
        end
      end
      ohq_pkg::S_EXEC: begin
        status_d = 1'b0;
        found_d  = 1'b0;
        ivalid_d = 1'b0;
        item_d   = '0;
        scan_d   = '0;
        pend_d   = 1'b0;
        unique case (cmd_q)
          ohq_pkg::CMD_APPEND: begin
            if (count_q >= CNT_W'(DEPTH)) begin
              status_d = 1'b1;
            end else begin
              we    = 1'b1;
              waddr = count_q[IDX_W-1:0];
              wdata = h_q;
              if (count_q == '0) begin
                cur_d       = '0;
                cur_valid_d = 1'b1;
              end
              count_d = count_q + CNT_W'(1);
            end
          end
          ohq_pkg::CMD_HEAD: begin
            if (count_q != '0) begin
              cur_d       = '0;
              cur_valid_d = 1'b1;
              ivalid_d    = 1'b1;
            end
          end
          ohq_pkg::CMD_NEXT: begin
            raddr = cur_inc[IDX_W-1:0];
            if (cur_valid_q) begin
              if (cur_inc < count_q) begin
                cur_d    = cur_inc[IDX_W-1:0];
                ivalid_d = 1'b1;
              end else begin
                cur_d       = '0;
                cur_valid_d = 1'b0;
              end
            end
          end
          ohq_pkg::CMD_CURRENT: begin
            raddr    = cur_q;
            ivalid_d = cur_valid_q && (cur_ext < count_q);
          end
          default: begin
          end
        endcase
      end
      ohq_pkg::S_SCAN: begin
        raddr = scan_q[IDX_W-1:0];
        if (hit) begin
          if (cmd_q == ohq_pkg::CMD_REMOVE) begin
            pos_d   = pidx_q;
            src_d   = CNT_W'(pidx_q) + CNT_W'(1);
            wpend_d = 1'b0;
          end else begin
            found_d = 1'b1;
          end
        end else if (scan_more) begin
          pend_d = 1'b1;
          pidx_d = scan_q[IDX_W-1:0];
          scan_d = scan_q + CNT_W'(1);
        end else if (cmd_q == ohq_pkg::CMD_REMOVE) begin
          status_d = 1'b1;
        end
      end
      ohq_pkg::S_SHIFT: begin
        raddr = src_q[IDX_W-1:0];
        we    = wpend_q;
        if (src_more) begin
          wpend_d = 1'b1;
          widx_d  = IDX_W'(src_q - CNT_W'(1));
          src_d   = src_q + CNT_W'(1);
        end else begin
          wpend_d = 1'b0;
          if (!wpend_q) begin
            count_d = count_dec;
            if (cur_valid_q) begin
              if (cur_q == pos_q) begin
                if (pos_ext >= count_dec) begin
                  cur_valid_d = 1'b0;
                  cur_d       = '0;
                end
              end else if (cur_q > pos_q) begin
                cur_d = cur_q - IDX_W'(1);
              end
            end else begin
              cur_d = '0;
            end
          end
        end
      end
      ohq_pkg::S_FETCH: item_d = rdata;
      ohq_pkg::S_DONE: load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ohq_pkg::S_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      wpend_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      pend_q      <= pend_d;
      wpend_q     <= wpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    h_q      <= h_d;
    scan_q   <= scan_d;
    pidx_q   <= pidx_d;
    pos_q    <= pos_d;
    src_q    <= src_d;
    widx_q   <= widx_d;
    status_q <= status_d;
    found_q  <= found_d;
    ivalid_q <= ivalid_d;
    item_q   <= item_d;
  end

  assign item_wide      = 64'(item_q);
  assign cnt_wide       = 32'(count_q);
  assign res.status     = status_q;
  assign res.found      = found_q;
  assign res.item_valid = ivalid_q;
  assign res.item       = item_wide[ohq_pkg::ITEM_W-1:0];
  assign res.count      = cnt_wide[ohq_pkg::COUNT_W-1:0];

  ohq_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .res_i        (res),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_o      (found_o),
    .item_valid_o (item_valid_o),
    .item_out_o   (item_out_o),
    .count_o      (count_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_ext < count_q))
    else $error("valid cursor outside the list");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ohq_pkg::S_EXEC && state_q != ohq_pkg::S_SHIFT) |=> $stable(count_q))
    else $error("count changed outside append or remove");

  a_ram_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ohq_pkg::S_EXEC || state_q == ohq_pkg::S_SHIFT))
    else $error("RAM written outside append or shift");

endmodule
`default_nettype wire

// ===== tb/ordered_handle_queue_core_tb.sv =====
// Self-checking testbench for the ordered handle queue core.
`timescale 1ns / 1ps
module ordered_handle_queue_core_tb;

  localparam int unsigned LIST_DEPTH = ohq_pkg::DEPTH_DEF;
  localparam logic [ohq_pkg::CMD_W-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [ohq_pkg::CMD_W-1:0] CMD_UNUSED7 = 3'd7;
  localparam int unsigned TAIL_CYCLES = 2 * LIST_DEPTH + 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [ohq_pkg::CMD_W-1:0] command_i = '0;
  logic [ohq_pkg::ITEM_W-1:0] item_handle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o;
  logic found_o;
  logic item_valid_o;
  logic [ohq_pkg::ITEM_W-1:0] item_out_o;
  logic [ohq_pkg::COUNT_W-1:0] count_o;

  ordered_handle_queue_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .command_i(command_i),
    .item_handle_i(item_handle_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o(status_o),
    .found_o(found_o),
    .item_valid_o(item_valid_o),
    .item_out_o(item_out_o),
    .count_o(count_o)
  );

  // predicted list state
  logic [ohq_pkg::ITEM_W-1:0] list_mem [LIST_DEPTH];
  int unsigned list_cnt = 0;
  int unsigned cursor_at = 0;
  bit cursor_ok = 1'b0;

  ohq_pkg::res_t pending_results [$];
  ohq_pkg::res_t want;
  logic [ohq_pkg::ITEM_W-1:0] handle_pool [8];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int find_handle(logic [ohq_pkg::ITEM_W-1:0] h);
    for (int i = 0; i < list_cnt; i++) begin
      if (list_mem[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic ohq_pkg::res_t predict_queue_cmd(logic [ohq_pkg::CMD_W-1:0] cmd,
                                                      logic [ohq_pkg::ITEM_W-1:0] h);
    ohq_pkg::res_t r;
    int idx;
    r = '0;
    case (cmd)
      ohq_pkg::CMD_APPEND: begin
        if (list_cnt >= LIST_DEPTH) begin
          r.status = 1'b1;
        end else begin
          list_mem[list_cnt] = h;
          if (list_cnt == 0) begin
            cursor_at = 0;
            cursor_ok = 1'b1;
          end
          list_cnt++;
        end
      end
      ohq_pkg::CMD_REMOVE: begin
        idx = find_handle(h);
        if (idx < 0) begin
          r.status = 1'b1;
        end else begin
          for (int i = idx; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i + 1];
          list_cnt--;
          if (cursor_ok) begin
            if (cursor_at == idx) begin
              if (idx >= list_cnt) cursor_ok = 1'b0;
            end else if (cursor_at > idx) begin
              cursor_at--;
            end
          end
          if (!cursor_ok) cursor_at = 0;
        end
      end
      ohq_pkg::CMD_HAS: r.found = (find_handle(h) >= 0);
      ohq_pkg::CMD_HEAD: begin
        if (list_cnt > 0) begin
          cursor_at = 0;
          cursor_ok = 1'b1;
          r.item_valid = 1'b1;
          r.item = list_mem[0];
        end
      end
      ohq_pkg::CMD_NEXT: begin
        if (cursor_ok) begin
          if (cursor_at + 1 < list_cnt) begin
            cursor_at++;
            r.item_valid = 1'b1;
            r.item = list_mem[cursor_at];
          end else begin
            cursor_ok = 1'b0;
            cursor_at = 0;
          end
        end
      end
      ohq_pkg::CMD_CURRENT: begin
        if (cursor_ok && cursor_at < list_cnt) begin
          r.item_valid = 1'b1;
          r.item = list_mem[cursor_at];
        end
      end
      default: ;
    endcase
    r.count = ohq_pkg::COUNT_W'(list_cnt);
    return r;
  endfunction

  function automatic void check_field(string name, logic [ohq_pkg::ITEM_W-1:0] exp_v,
                                      logic [ohq_pkg::ITEM_W-1:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got count %0d", $time, count_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", ohq_pkg::ITEM_W'(want.status), ohq_pkg::ITEM_W'(status_o));
        check_field("found", ohq_pkg::ITEM_W'(want.found), ohq_pkg::ITEM_W'(found_o));
        check_field("item_valid", ohq_pkg::ITEM_W'(want.item_valid),
                    ohq_pkg::ITEM_W'(item_valid_o));
        check_field("item_out", want.item, item_out_o);
        check_field("count", ohq_pkg::ITEM_W'(want.count), ohq_pkg::ITEM_W'(count_o));
      end
    end
  end

  // receiver: random stalls, or a long hold-off while hold_left runs down
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_request(logic [ohq_pkg::CMD_W-1:0] cmd,
                              logic [ohq_pkg::ITEM_W-1:0] h);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    item_handle_i <= h;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_queue_cmd(cmd, h));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ohq_pkg::ITEM_W-1:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 45) return handle_pool[$urandom_range(7)];
    if (r < 75 && list_cnt > 0) return list_mem[$urandom_range(list_cnt - 1)];
    return ohq_pkg::ITEM_W'($urandom);
  endfunction

  task automatic test_corner_cases();
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    send_request(ohq_pkg::CMD_HEAD, 16'hFFFF);
    send_request(ohq_pkg::CMD_REMOVE, 16'h0000);
    send_request(ohq_pkg::CMD_HAS, 16'hFFFF);
    send_request(ohq_pkg::CMD_APPEND, 16'h0000);
    send_request(ohq_pkg::CMD_CURRENT, 16'hFFFF);
    send_request(ohq_pkg::CMD_APPEND, 16'hFFFF);
    send_request(ohq_pkg::CMD_APPEND, 16'h0000);
    send_request(ohq_pkg::CMD_HAS, 16'hFFFF);
    send_request(ohq_pkg::CMD_HAS, 16'h5A5A);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(ohq_pkg::CMD_APPEND, 16'h1234);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(ohq_pkg::CMD_HEAD, 16'h0000);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    // drop an entry ahead of the cursor, then the one under it
    send_request(ohq_pkg::CMD_REMOVE, 16'h0000);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(ohq_pkg::CMD_REMOVE, 16'hFFFF);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(CMD_UNUSED6, 16'hFFFF);
    send_request(CMD_UNUSED7, 16'h0000);
    send_request(ohq_pkg::CMD_REMOVE, 16'h5A5A);
  endtask

  task automatic test_full_list();
    int unsigned k;
    k = 0;
    while (list_cnt < LIST_DEPTH) begin
      send_request(ohq_pkg::CMD_APPEND, 16'hA500 | ohq_pkg::ITEM_W'(k));
      k++;
    end
    send_request(ohq_pkg::CMD_APPEND, 16'hBEEF);
    send_request(ohq_pkg::CMD_HEAD, 16'h0000);
    for (int i = 1; i < LIST_DEPTH; i++) send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    // removing the tail under the cursor leaves it pointing nowhere
    send_request(ohq_pkg::CMD_REMOVE, list_mem[list_cnt - 1]);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
    send_request(ohq_pkg::CMD_APPEND, 16'h7777);
    send_request(ohq_pkg::CMD_NEXT, 16'h0000);
    while (list_cnt > 0) send_request(ohq_pkg::CMD_REMOVE, list_mem[0]);
    send_request(ohq_pkg::CMD_CURRENT, 16'h0000);
  endtask

  task automatic test_random_traffic(int n, int idle, int stall, int append_w);
    int pick;
    logic [ohq_pkg::CMD_W-1:0] c;
    idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(append_w + 77);
      if (pick < append_w) c = ohq_pkg::CMD_APPEND;
      else if (pick < append_w + 25) c = ohq_pkg::CMD_REMOVE;
      else if (pick < append_w + 40) c = ohq_pkg::CMD_HAS;
      else if (pick < append_w + 50) c = ohq_pkg::CMD_HEAD;
      else if (pick < append_w + 64) c = ohq_pkg::CMD_NEXT;
      else if (pick < append_w + 75) c = ohq_pkg::CMD_CURRENT;
      else c = $urandom_range(1) ? CMD_UNUSED7 : CMD_UNUSED6;
      send_request(c, pick_handle());
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    for (int k = 0; k < 40; k++) begin
      send_request($urandom_range(1) ? ohq_pkg::CMD_APPEND : ohq_pkg::CMD_REMOVE,
                   pick_handle());
    end
    wait_drain();
  endtask

  initial begin
    handle_pool[0] = 16'h0000;
    handle_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) handle_pool[i] = ohq_pkg::ITEM_W'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    wait_drain();
    test_full_list();
    wait_drain();
    test_random_traffic(100, 0, 0, 30);
    test_random_traffic(100, 60, 0, 20);
    test_random_traffic(100, 0, 60, 35);
    test_backpressure();
    test_random_traffic(100, 21, 21, 28);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
